// ===== rtl/core/kwm_pkg.sv =====
// Package for the k-way run merge: configuration register indexes and the
// control word passed from the top level to the head store.
// No dependencies.
package kwm_pkg;

   localparam int CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_DESCENDING  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RUNS_IN_USE = 1'b1;

   // Per-word control for the head store
   typedef struct packed {
      logic advance;   // registered word is consumed this cycle
      logic run_done;  // registered word is an end mark
      logic decide;    // no in-use run is still awaited: emit this cycle
   } kwm_ctl_type;

endpackage

// ===== rtl/core/kwm_heads.sv =====
// Head store of the k-way run merge: one key/tag head per run, head valid
// bits and the awaiting mask, with the next-state view used for selection.
// Depends on kwm_pkg.
module kwm_heads
   import kwm_pkg::*;
#(
   parameter int MAX_RUNS  = 8,
   parameter int KEY_WIDTH = 32,
   parameter int TAG_WIDTH = 16,
   localparam int RUN_W    = $clog2(MAX_RUNS)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  kwm_ctl_type                 ctl,
   input  logic                        found,
   input  logic [MAX_RUNS-1:0]         use_mask,
   input  logic [RUN_W-1:0]            item_run,
   input  logic signed [KEY_WIDTH-1:0] item_key,
   input  logic [TAG_WIDTH-1:0]        item_tag,
   input  logic [RUN_W-1:0]            best_run,
   output logic signed [KEY_WIDTH-1:0] keys_nx [MAX_RUNS],
   output logic [TAG_WIDTH-1:0]        tags_nx [MAX_RUNS],
   output logic [MAX_RUNS-1:0]         valid_nx,
   output logic [MAX_RUNS-1:0]         await_nx
);

   logic signed [KEY_WIDTH-1:0] keys_ff [MAX_RUNS];
   logic [TAG_WIDTH-1:0]        tags_ff [MAX_RUNS];
   logic [MAX_RUNS-1:0]         valid_ff, valid_in;
   logic [MAX_RUNS-1:0]         await_ff, await_in;
   logic [MAX_RUNS-1:0]         sel;
   logic [MAX_RUNS-1:0]         hit;
   logic [MAX_RUNS-1:0]         best_sel;

   always_comb begin
      for (int i = 0; i < MAX_RUNS; i++) begin
         sel[i]      = (item_run == RUN_W'(i));
         best_sel[i] = (best_run == RUN_W'(i));
      end
      // only an awaited, in-use run takes the word
      hit = sel & use_mask & await_ff;
   end

   always_comb begin
      for (int i = 0; i < MAX_RUNS; i++) begin
         keys_nx[i] = (hit[i] && !ctl.run_done) ? item_key : keys_ff[i];
         tags_nx[i] = (hit[i] && !ctl.run_done) ? item_tag : tags_ff[i];
      end
      valid_nx = ctl.run_done ? (valid_ff & ~hit) : (valid_ff | hit);
      await_nx = await_ff & ~hit;
   end

   always_comb begin
      valid_in = valid_ff;
      await_in = await_ff;
      if (ctl.advance) begin
         valid_in = valid_nx;
         await_in = await_nx;
         if (ctl.decide) begin
            if (found) begin
               valid_in = valid_nx & ~best_sel;
               await_in = best_sel;
            end else begin
               valid_in = '0;
               await_in = '1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         await_ff <= '1;
      end else begin
         valid_ff <= valid_in;
         await_ff <= await_in;
      end
   end

   // payload: written only where a row lands
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RUNS; i++) begin
         if (ctl.advance && hit[i] && !ctl.run_done) begin
            keys_ff[i] <= item_key;
            tags_ff[i] <= item_tag;
         end
      end
   end

endmodule

// ===== rtl/core/kwm_select.sv =====
// Head selection of the k-way run merge: picks the first head in merge
// order among valid in-use runs, lowest run number on ties.
// Depends on kwm_pkg.
module kwm_select
   import kwm_pkg::*;
#(
   parameter int MAX_RUNS  = 8,
   parameter int KEY_WIDTH = 32,
   localparam int RUN_W    = $clog2(MAX_RUNS),
   localparam int LEAVES   = 1 << RUN_W
) (
   input  logic                        descending,
   input  logic [MAX_RUNS-1:0]         use_mask,
   input  logic [MAX_RUNS-1:0]         valid_nx,
   input  logic signed [KEY_WIDTH-1:0] keys_nx [MAX_RUNS],
   output logic                        found,
   output logic [RUN_W-1:0]            best_run
);

   function automatic logic goes_first(input logic desc,
                                       input logic signed [KEY_WIDTH-1:0] a,
                                       input logic signed [KEY_WIDTH-1:0] b);
      return desc ? (a > b) : (a < b);
   endfunction

   logic [MAX_RUNS-1:0]         cand;
   // compare tree, node n fed by nodes 2n (lower runs) and 2n+1
   logic                        t_ok  [2*LEAVES];
   logic [RUN_W-1:0]            t_run [2*LEAVES];
   logic signed [KEY_WIDTH-1:0] t_key [2*LEAVES];

   always_comb begin
      cand = valid_nx & use_mask;
      for (int i = 0; i < 2*LEAVES; i++) begin
         t_ok[i]  = 1'b0;
         t_run[i] = '0;
         t_key[i] = '0;
      end
      for (int i = 0; i < MAX_RUNS; i++) begin
         t_ok[LEAVES + i]  = cand[i];
         t_run[LEAVES + i] = RUN_W'(i);
         t_key[LEAVES + i] = keys_nx[i];
      end
      // strict compare keeps the lower side on equal keys
      for (int n = LEAVES - 1; n >= 1; n--) begin
         if (t_ok[2*n+1] && (!t_ok[2*n] ||
                             goes_first(descending, t_key[2*n+1], t_key[2*n]))) begin
            t_ok[n]  = 1'b1;
            t_run[n] = t_run[2*n+1];
            t_key[n] = t_key[2*n+1];
         end else begin
            t_ok[n]  = t_ok[2*n];
            t_run[n] = t_run[2*n];
            t_key[n] = t_key[2*n];
         end
      end
      found    = t_ok[1];
      best_run = t_run[1];
   end

endmodule

// ===== rtl/core/k_way_run_merge.sv =====
// K-way merge of sorted runs: input word register, head store, head
// selection and result register. Depends on kwm_pkg, kwm_heads, kwm_select.
//
//   channel  handshake           payload
//   req      req_valid/ready     req_run, req_key, req_row_tag, req_run_done
//   rsp      rsp_valid/ready     rsp_out_run, rsp_out_key, rsp_out_tag,
//                                rsp_merge_done
//   csr      csr_we              csr_index, csr_wdata (write only)
//
// One word per cycle while the result register is empty or taken. A word is
// held in the input register, then the head update and the compare tree over
// all heads run combinationally into the result register.
// The input register drains whenever the result register is empty or taken.
// Reset is synchronous; it clears all heads, awaits every run, and sets
// ascending order with all runs in use.
module k_way_run_merge
   import kwm_pkg::*;
#(
   parameter int MAX_RUNS  = 8,
   parameter int KEY_WIDTH = 32,
   parameter int TAG_WIDTH = 16,
   localparam int RUN_W    = $clog2(MAX_RUNS),
   localparam int CNT_W    = $clog2(MAX_RUNS + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [RUN_W-1:0]            req_run,
   input  logic signed [KEY_WIDTH-1:0] req_key,
   input  logic [TAG_WIDTH-1:0]        req_row_tag,
   input  logic                        req_run_done,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [RUN_W-1:0]            rsp_out_run,
   output logic signed [KEY_WIDTH-1:0] rsp_out_key,
   output logic [TAG_WIDTH-1:0]        rsp_out_tag,
   output logic                        rsp_merge_done,
   input  logic                        csr_we,
   input  logic [CSR_INDEX_W-1:0]      csr_index,
   input  logic [CNT_W-1:0]            csr_wdata
);

   logic                        descending_ff;
   logic [CNT_W-1:0]            runs_ff;
   logic [CNT_W-1:0]            runs_eff;
   logic [MAX_RUNS-1:0]         use_mask;

   logic                        in_valid_ff;
   logic [RUN_W-1:0]            in_run_ff;
   logic signed [KEY_WIDTH-1:0] in_key_ff;
   logic [TAG_WIDTH-1:0]        in_tag_ff;
   logic                        in_done_ff;

   logic                        rsp_valid_ff;
   logic [RUN_W-1:0]            out_run_ff;
   logic signed [KEY_WIDTH-1:0] out_key_ff;
   logic [TAG_WIDTH-1:0]        out_tag_ff;
   logic                        merge_done_ff;

   logic signed [KEY_WIDTH-1:0] keys_nx [MAX_RUNS];
   logic [TAG_WIDTH-1:0]        tags_nx [MAX_RUNS];
   logic [MAX_RUNS-1:0]         valid_nx;
   logic [MAX_RUNS-1:0]         await_nx;
   logic                        found;
   logic [RUN_W-1:0]            best_run;
   logic                        advance;
   kwm_ctl_type                 ctl;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         descending_ff <= 1'b0;
         runs_ff       <= CNT_W'(MAX_RUNS);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DESCENDING:  descending_ff <= csr_wdata[0];
            CSR_RUNS_IN_USE: runs_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clamp the run count into 1..MAX_RUNS
   always_comb begin
      if (runs_ff == '0) begin
         runs_eff = CNT_W'(1);
      end else if (runs_ff > CNT_W'(MAX_RUNS)) begin
         runs_eff = CNT_W'(MAX_RUNS);
      end else begin
         runs_eff = runs_ff;
      end
      for (int i = 0; i < MAX_RUNS; i++) begin
         use_mask[i] = (CNT_W'(i) < runs_eff);
      end
   end

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // input word register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_run_ff  <= req_run;
         in_key_ff  <= req_key;
         in_tag_ff  <= req_row_tag;
         in_done_ff <= req_run_done;
      end
   end

   always_comb begin
      ctl.advance  = advance;
      ctl.run_done = in_done_ff;
      ctl.decide   = ((await_nx & use_mask) == '0);
   end

   kwm_heads #(
      .MAX_RUNS  (MAX_RUNS),
      .KEY_WIDTH (KEY_WIDTH),
      .TAG_WIDTH (TAG_WIDTH)
   ) u_heads (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .found    (found),
      .use_mask (use_mask),
      .item_run (in_run_ff),
      .item_key (in_key_ff),
      .item_tag (in_tag_ff),
      .best_run (best_run),
      .keys_nx  (keys_nx),
      .tags_nx  (tags_nx),
      .valid_nx (valid_nx),
      .await_nx (await_nx)
   );

   kwm_select #(
      .MAX_RUNS  (MAX_RUNS),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_select (
      .descending (descending_ff),
      .use_mask   (use_mask),
      .valid_nx   (valid_nx),
      .keys_nx    (keys_nx),
      .found      (found),
      .best_run   (best_run)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && ctl.decide) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && ctl.decide) begin
         if (found) begin
            out_run_ff    <= best_run;
            out_key_ff    <= keys_nx[best_run];
            out_tag_ff    <= tags_nx[best_run];
            merge_done_ff <= 1'b0;
         end else begin
            out_run_ff    <= '0;
            out_key_ff    <= '0;
            out_tag_ff    <= '0;
            merge_done_ff <= 1'b1;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_run    = out_run_ff;
   assign rsp_out_key    = out_key_ff;
   assign rsp_out_tag    = out_tag_ff;
   assign rsp_merge_done = merge_done_ff;

endmodule
